@@ src/ihp_pkg.sv @@
// Shared types and constants for the indexed priority heap unit.
// Holds field widths, request and status codes, controller states and status flags.
`default_nettype none
package ihp_pkg;

  localparam int DEPTH_DEF = 1024;
  localparam int ENT_W = 10;
  localparam int CNT_W = 11;
  localparam int REQ_W = 2;
  localparam int STAT_W = 2;

  localparam logic [REQ_W-1:0] REQ_LOAD   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DEC    = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_ABSENT = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE  = 2'd2;

  typedef enum logic [18:0] {
    S_IDLE = 19'd1 << 0,
    S_LOAD = 19'd1 << 1,
    S_BN   = 19'd1 << 2,
    S_BR   = 19'd1 << 3,
    S_BC   = 19'd1 << 4,
    S_Q1   = 19'd1 << 5,
    S_Q2   = 19'd1 << 6,
    S_Q3   = 19'd1 << 7,
    S_RM1  = 19'd1 << 8,
    S_RM2  = 19'd1 << 9,
    S_SDA  = 19'd1 << 10,
    S_SDB  = 19'd1 << 11,
    S_SDC  = 19'd1 << 12,
    S_SUA  = 19'd1 << 13,
    S_SUB  = 19'd1 << 14,
    S_SUC  = 19'd1 << 15,
    S_F1   = 19'd1 << 16,
    S_F2   = 19'd1 << 17,
    S_F3   = 19'd1 << 18
  } state_t;

  typedef struct packed {
    logic go;
    logic new_load;
    logic new_query;
    logic last;
    logic queued;
    logic is_remove;
    logic at_end;
    logic cnt_nz;
    logic sd_leaf;
    logic sd_move;
    logic su_root;
    logic su_win;
    logic moved;
    logic bidx_zero;
    logic build;
    logic out_free;
  } ihp_stat_t;

endpackage
`default_nettype wire

@@ src/ihp_if.sv @@
// Valid/ready channel interfaces for request beats and result beats.
// Depends on ihp_pkg for the field widths.
`default_nettype none
interface ihp_in_if;
  import ihp_pkg::*;
  logic valid;
  logic ready;
  logic [REQ_W-1:0] req_type;
  logic [ENT_W-1:0] entry;
  logic [CNT_W-1:0] count_value;
  logic load_last;
  modport source (output valid, req_type, entry, count_value, load_last, input ready);
  modport sink (input valid, req_type, entry, count_value, load_last, output ready);
endinterface

interface ihp_out_if;
  import ihp_pkg::*;
  logic valid;
  logic ready;
  logic [ENT_W-1:0] top_entry;
  logic [CNT_W-1:0] top_count;
  logic [CNT_W-1:0] heap_size;
  logic is_empty;
  logic entry_present;
  logic [STAT_W-1:0] status;
  modport source (output valid, top_entry, top_count, heap_size, is_empty, entry_present,
                  status, input ready);
  modport sink (input valid, top_entry, top_count, heap_size, is_empty, entry_present,
                status, output ready);
endinterface
`default_nettype wire

@@ src/ihp_ctrl.sv @@
// Controller state machine of the indexed priority heap unit.
// Sequences load, build, query, sift and report steps; depends on ihp_pkg.
`default_nettype none
module ihp_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ihp_pkg::ihp_stat_t st,
  output ihp_pkg::state_t        cmd
);
  import ihp_pkg::*;

  state_t state_r, state_nxt;

  assign cmd = state_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (st.go) begin
          if (st.new_load) state_nxt = S_LOAD;
          else if (st.new_query) state_nxt = S_Q1;
          else state_nxt = S_F1;
        end
      end
      S_LOAD: state_nxt = st.last ? S_BN : S_F1;
      S_BN:   state_nxt = st.bidx_zero ? S_F1 : S_BR;
      S_BR:   state_nxt = S_BC;
      S_BC:   state_nxt = S_SDA;
      S_SDA: begin
        if (st.sd_leaf) state_nxt = st.build ? S_BN : S_F1;
        else state_nxt = S_SDB;
      end
      S_SDB:  state_nxt = S_SDC;
      S_SDC: begin
        if (st.sd_move) state_nxt = S_SDA;
        else state_nxt = st.build ? S_BN : S_F1;
      end
      S_Q1:   state_nxt = S_Q2;
      S_Q2:   state_nxt = S_Q3;
      S_Q3: begin
        if (!st.queued) state_nxt = S_F1;
        else if (st.is_remove) state_nxt = st.at_end ? S_F1 : S_RM1;
        else state_nxt = st.cnt_nz ? S_SDA : S_F1;
      end
      S_RM1:  state_nxt = S_RM2;
      S_RM2:  state_nxt = S_SUA;
      S_SUA: begin
        if (st.su_root) state_nxt = st.moved ? S_F1 : S_SDA;
        else state_nxt = S_SUB;
      end
      S_SUB:  state_nxt = S_SUC;
      S_SUC: begin
        if (st.su_win) state_nxt = S_SUA;
        else state_nxt = st.moved ? S_F1 : S_SDA;
      end
      S_F1:   state_nxt = S_F2;
      S_F2:   state_nxt = S_F3;
      S_F3:   state_nxt = st.out_free ? S_IDLE : S_F3;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

@@ src/ihp_dp.sv @@
// Datapath of the indexed priority heap unit: heap, position and count memories,
// sift registers and the result register. Depends on ihp_pkg and ihp_if.
`default_nettype none
module ihp_dp #(
  parameter int DEPTH = ihp_pkg::DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  ihp_pkg::state_t cmd,
  output ihp_pkg::ihp_stat_t st,
  ihp_in_if.sink          in_bus,
  ihp_out_if.source       out_bus
);
  import ihp_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [AW-1:0]    heap_mem [DEPTH];
  logic [AW-1:0]    pos_mem  [DEPTH];
  logic [CNT_W-1:0] cnt_mem  [DEPTH];

  logic [AW-1:0]    ha_addr, hb_addr, ha_q, hb_q, hw_addr, hw_data;
  logic [AW-1:0]    pa_addr, pa_q, pw_addr, pw_data;
  logic [AW-1:0]    ca_addr, cb_addr, cw_addr;
  logic [CNT_W-1:0] ca_q, cb_q, cw_data;
  logic             hw_en, pw_en, cw_en;

  logic [REQ_W-1:0]  req_r, req_nxt;
  logic [ENT_W-1:0]  ent_r, ent_nxt;
  logic [CNT_W-1:0]  cval_r, cval_nxt;
  logic              last_r, last_nxt;
  logic              chk_r, chk_nxt;
  logic [STAT_W-1:0] stat_r, stat_nxt;
  logic [CW-1:0]     size_r, size_nxt;
  logic [CW-1:0]     cursor_r, cursor_nxt;
  logic [CW-1:0]     bidx_r, bidx_nxt;
  logic              build_r, build_nxt;
  logic              moved_r, moved_nxt;
  logic              rok_r, rok_nxt;
  logic [AW-1:0]     p_r, p_nxt;
  logic [AW-1:0]     ep_r, ep_nxt;
  logic [CNT_W-1:0]  cp_r, cp_nxt;
  logic [AW-1:0]     hl_r, hl_nxt;
  logic [AW-1:0]     hr_r, hr_nxt;
  logic [AW-1:0]     pe_r, pe_nxt;
  logic [AW-1:0]     top_r, top_nxt;

  logic              ov_r, ov_nxt;
  logic [ENT_W-1:0]  o_top_r, o_top_nxt;
  logic [CNT_W-1:0]  o_cnt_r, o_cnt_nxt;
  logic [CNT_W-1:0]  o_size_r, o_size_nxt;
  logic              o_empty_r, o_empty_nxt;
  logic              o_pres_r, o_pres_nxt;
  logic [STAT_W-1:0] o_stat_r, o_stat_nxt;

  logic [AW-1:0] e_idx, parent, pick_e, pick_slot;
  logic [AW:0]   lr, rr;
  logic [CW-1:0] cur_new;
  logic [CNT_W-1:0] pick_c;
  logic accept, bus_rmdec, bus_inrange, pick_r, out_free;

  function automatic logic wins(input logic [CNT_W-1:0] ca, input logic [AW-1:0] ea,
                                input logic [CNT_W-1:0] cb, input logic [AW-1:0] eb);
    return (ca > cb) || ((ca == cb) && (ea < eb));
  endfunction

  always_ff @(posedge clk) begin
    ha_q <= heap_mem[ha_addr];
    hb_q <= heap_mem[hb_addr];
    if (hw_en) heap_mem[hw_addr] <= hw_data;
  end

  always_ff @(posedge clk) begin
    pa_q <= pos_mem[pa_addr];
    if (pw_en) pos_mem[pw_addr] <= pw_data;
  end

  always_ff @(posedge clk) begin
    ca_q <= cnt_mem[ca_addr];
    cb_q <= cnt_mem[cb_addr];
    if (cw_en) cnt_mem[cw_addr] <= cw_data;
  end

  assign in_bus.ready = (cmd == S_IDLE);
  assign accept       = in_bus.valid && in_bus.ready;
  assign bus_rmdec    = (in_bus.req_type == REQ_REMOVE) || (in_bus.req_type == REQ_DEC);
  assign bus_inrange  = in_bus.entry < DEPTH;
  assign out_free     = !ov_r || out_bus.ready;

  assign e_idx  = AW'(ent_r);
  assign parent = AW'((p_r - AW'(1)) >> 1);
  assign lr     = {p_r, 1'b1};
  assign rr     = lr + (AW+1)'(1);
  assign pick_r = rok_r && wins(cb_q, hr_r, ca_q, hl_r);
  assign pick_e = pick_r ? hr_r : hl_r;
  assign pick_c = pick_r ? cb_q : ca_q;
  assign pick_slot = pick_r ? AW'(hl_r == hl_r ? AW'(p_r * 2 + 2) : '0) : AW'(p_r * 2 + 1);
  assign cur_new = (cursor_r < DEPTH) ? cursor_r + CW'(1) : cursor_r;

  always_comb begin
    st.go        = in_bus.valid;
    st.new_load  = in_bus.req_type == REQ_LOAD;
    st.new_query = bus_rmdec && bus_inrange;
    st.last      = last_r;
    st.queued    = (CW'(pe_r) < size_r) && (ha_q == e_idx);
    st.is_remove = req_r == REQ_REMOVE;
    st.at_end    = CW'(pe_r) == size_r - CW'(1);
    st.cnt_nz    = ca_q != '0;
    st.sd_leaf   = lr >= size_r;
    st.sd_move   = wins(pick_c, pick_e, cp_r, ep_r);
    st.su_root   = p_r == '0;
    st.su_win    = wins(cp_r, ep_r, ca_q, hl_r);
    st.moved     = moved_r;
    st.bidx_zero = bidx_r == '0;
    st.build     = build_r;
    st.out_free  = out_free;
  end

  always_comb begin
    ha_addr = '0; hb_addr = '0; pa_addr = '0; ca_addr = '0; cb_addr = '0;
    hw_en = 1'b0; hw_addr = p_r; hw_data = ep_r;
    pw_en = 1'b0; pw_addr = ep_r; pw_data = p_r;
    cw_en = 1'b0; cw_addr = e_idx; cw_data = ca_q - CNT_W'(1);
    req_nxt = req_r; ent_nxt = ent_r; cval_nxt = cval_r; last_nxt = last_r;
    chk_nxt = chk_r; stat_nxt = stat_r; size_nxt = size_r; cursor_nxt = cursor_r;
    bidx_nxt = bidx_r; build_nxt = build_r; moved_nxt = moved_r; rok_nxt = rok_r;
    p_nxt = p_r; ep_nxt = ep_r; cp_nxt = cp_r; hl_nxt = hl_r; hr_nxt = hr_r;
    pe_nxt = pe_r; top_nxt = top_r;
    ov_nxt = ov_r && !out_bus.ready;
    o_top_nxt = o_top_r; o_cnt_nxt = o_cnt_r; o_size_nxt = o_size_r;
    o_empty_nxt = o_empty_r; o_pres_nxt = o_pres_r; o_stat_nxt = o_stat_r;
    case (cmd)
      S_IDLE: begin
        if (accept) begin
          req_nxt   = in_bus.req_type;
          ent_nxt   = in_bus.entry;
          cval_nxt  = in_bus.count_value;
          last_nxt  = in_bus.load_last;
          chk_nxt   = bus_rmdec && bus_inrange;
          stat_nxt  = (bus_rmdec && !bus_inrange) ? STAT_RANGE : STAT_OK;
          build_nxt = 1'b0;
        end
      end
      S_LOAD: begin
        if (cursor_r == '0) size_nxt = '0;
        if (cursor_r < DEPTH) begin
          hw_en = 1'b1; hw_addr = AW'(cursor_r); hw_data = AW'(cursor_r);
          pw_en = 1'b1; pw_addr = AW'(cursor_r); pw_data = AW'(cursor_r);
          cw_en = 1'b1; cw_addr = AW'(cursor_r); cw_data = cval_r;
        end else begin
          stat_nxt = STAT_RANGE;
        end
        if (last_r) begin
          size_nxt   = cur_new;
          bidx_nxt   = cur_new >> 1;
          build_nxt  = 1'b1;
          cursor_nxt = '0;
        end else begin
          cursor_nxt = cur_new;
        end
      end
      S_BN: begin
        if (bidx_r != '0) begin
          p_nxt    = AW'(bidx_r - CW'(1));
          ha_addr  = AW'(bidx_r - CW'(1));
          bidx_nxt = bidx_r - CW'(1);
        end else begin
          build_nxt = 1'b0;
        end
      end
      S_BR: begin
        ep_nxt  = ha_q;
        ca_addr = ha_q;
      end
      S_BC: cp_nxt = ca_q;
      S_SDA: begin
        if (lr >= size_r) begin
          hw_en = 1'b1; pw_en = 1'b1;
        end else begin
          ha_addr = lr[AW-1:0];
          hb_addr = rr[AW-1:0];
          rok_nxt = rr < size_r;
        end
      end
      S_SDB: begin
        hl_nxt  = ha_q;
        hr_nxt  = hb_q;
        ca_addr = ha_q;
        cb_addr = hb_q;
      end
      S_SDC: begin
        hw_en = 1'b1; pw_en = 1'b1;
        if (wins(pick_c, pick_e, cp_r, ep_r)) begin
          hw_data = pick_e;
          pw_addr = pick_e;
          p_nxt   = pick_slot;
        end
      end
      S_Q1: pa_addr = e_idx;
      S_Q2: begin
        pe_nxt  = pa_q;
        ha_addr = pa_q;
        ca_addr = e_idx;
      end
      S_Q3: begin
        moved_nxt = 1'b0;
        p_nxt     = pe_r;
        if (!((CW'(pe_r) < size_r) && (ha_q == e_idx))) begin
          stat_nxt = STAT_ABSENT;
        end else if (req_r == REQ_REMOVE) begin
          size_nxt = size_r - CW'(1);
          pw_en = 1'b1; pw_addr = e_idx; pw_data = AW'(size_r - CW'(1));
          ha_addr = AW'(size_r - CW'(1));
        end else if (ca_q != '0) begin
          cw_en  = 1'b1;
          ep_nxt = e_idx;
          cp_nxt = ca_q - CNT_W'(1);
        end
      end
      S_RM1: begin
        ep_nxt  = ha_q;
        ca_addr = ha_q;
      end
      S_RM2: cp_nxt = ca_q;
      S_SUA: begin
        if (p_r == '0) begin
          if (moved_r) begin
            hw_en = 1'b1; pw_en = 1'b1;
          end
        end else begin
          ha_addr = parent;
        end
      end
      S_SUB: begin
        hl_nxt  = ha_q;
        ca_addr = ha_q;
      end
      S_SUC: begin
        if (wins(cp_r, ep_r, ca_q, hl_r)) begin
          hw_en = 1'b1; hw_data = hl_r;
          pw_en = 1'b1; pw_addr = hl_r;
          p_nxt = parent;
          moved_nxt = 1'b1;
        end else if (moved_r) begin
          hw_en = 1'b1; pw_en = 1'b1;
        end
      end
      S_F1: begin
        ha_addr = '0;
        pa_addr = e_idx;
      end
      S_F2: begin
        top_nxt = ha_q;
        pe_nxt  = pa_q;
        ca_addr = ha_q;
        hb_addr = pa_q;
      end
      S_F3: begin
        ca_addr = top_r;
        hb_addr = pe_r;
        if (out_free) begin
          ov_nxt      = 1'b1;
          o_top_nxt   = (size_r != '0) ? ENT_W'(top_r) : '0;
          o_cnt_nxt   = (size_r != '0) ? ca_q : '0;
          o_size_nxt  = CNT_W'(size_r);
          o_empty_nxt = size_r == '0;
          o_pres_nxt  = chk_r && (CW'(pe_r) < size_r) && (hb_q == e_idx);
          o_stat_nxt  = stat_r;
        end
      end
      default: begin
        ov_nxt = ov_r && !out_bus.ready;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r   <= '0;
      cursor_r <= '0;
      build_r  <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      size_r   <= size_nxt;
      cursor_r <= cursor_nxt;
      build_r  <= build_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt; ent_r <= ent_nxt; cval_r <= cval_nxt; last_r <= last_nxt;
    chk_r <= chk_nxt; stat_r <= stat_nxt; bidx_r <= bidx_nxt; moved_r <= moved_nxt;
    rok_r <= rok_nxt; p_r <= p_nxt; ep_r <= ep_nxt; cp_r <= cp_nxt;
    hl_r <= hl_nxt; hr_r <= hr_nxt; pe_r <= pe_nxt; top_r <= top_nxt;
    o_top_r <= o_top_nxt; o_cnt_r <= o_cnt_nxt; o_size_r <= o_size_nxt;
    o_empty_r <= o_empty_nxt; o_pres_r <= o_pres_nxt; o_stat_r <= o_stat_nxt;
  end

  assign out_bus.valid         = ov_r;
  assign out_bus.top_entry     = o_top_r;
  assign out_bus.top_count     = o_cnt_r;
  assign out_bus.heap_size     = o_size_r;
  assign out_bus.is_empty      = o_empty_r;
  assign out_bus.entry_present = o_pres_r;
  assign out_bus.status        = o_stat_r;

endmodule
`default_nettype wire

@@ src/indexed_priority_heap_unit.sv @@
// Indexed priority heap unit: an indexed binary max-heap of up to DEPTH entries keyed
// by counts (higher count first, lower entry number on a tie). Each request beat
// (load, remove or decrement) yields one result beat with the root entry, its count,
// the heap size, empty and presence flags and a status. One request is worked at a
// time; a new beat is taken while the previous result waits in the output register.
// A remove moves the last entry into the freed slot and sifts it up or down; a decrement
// sifts the entry down; each heap level is a pass of read, compare and write. A plain
// load writes one entry; the final load of a batch builds the heap, sifting down each
// visited entry from the last parent back to the root.
// No clearing pass follows reset: the stores are valid once loaded.
`default_nettype none
module indexed_priority_heap_unit #(
  parameter int DEPTH = ihp_pkg::DEPTH_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  ihp_in_if.sink    in_bus,
  ihp_out_if.source out_bus
);
  import ihp_pkg::*;

  state_t    cmd;
  ihp_stat_t st;

  ihp_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .st    (st),
    .cmd   (cmd)
  );

  ihp_dp #(.DEPTH(DEPTH)) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .st      (st),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

endmodule
`default_nettype wire

@@ src/ihp_checker.sv @@
// Port-level checker for the indexed priority heap unit and its bind statement.
// Depends on ihp_pkg for widths and status codes.
`default_nettype none
module ihp_checker (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic [ihp_pkg::ENT_W-1:0]  top_entry,
  input wire logic [ihp_pkg::CNT_W-1:0]  top_count,
  input wire logic [ihp_pkg::CNT_W-1:0]  heap_size,
  input wire logic                      is_empty,
  input wire logic                      entry_present,
  input wire logic [ihp_pkg::STAT_W-1:0] status
);
  import ihp_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> is_empty == (heap_size == '0))
    else $error("empty flag disagrees with heap size");

  a_root: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && is_empty |-> top_entry == '0 && top_count == '0)
    else $error("empty heap reports a root");

  a_pres: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != STAT_OK |-> !entry_present)
    else $error("ignored request reports entry present");

endmodule

bind indexed_priority_heap_unit ihp_checker u_ihp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_bus.valid),
  .out_ready     (out_bus.ready),
  .top_entry     (out_bus.top_entry),
  .top_count     (out_bus.top_count),
  .heap_size     (out_bus.heap_size),
  .is_empty      (out_bus.is_empty),
  .entry_present (out_bus.entry_present),
  .status        (out_bus.status)
);
`default_nettype wire

@@ tb/indexed_priority_heap_unit_tb.sv @@
// Self-checking testbench for the indexed priority heap unit: request beats in, result beats out.
// Keeps its own heap model to predict each result. Depends on ihp_pkg, ihp_if and the top module.
`default_nettype none
module indexed_priority_heap_unit_tb;
  import ihp_pkg::*;

  localparam int DEPTH = 1024;
  localparam int WATCHDOG_LIMIT = 200000;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [ENT_W-1:0] entry;
    logic [CNT_W-1:0] count_value;
    logic load_last;
  } req_beat_t;

  typedef struct packed {
    logic [ENT_W-1:0] top_entry;
    logic [CNT_W-1:0] top_count;
    logic [CNT_W-1:0] heap_size;
    logic is_empty;
    logic entry_present;
    logic [STAT_W-1:0] status;
  } res_beat_t;

  logic clk;
  logic rst_n;
  ihp_in_if in_bus ();
  ihp_out_if out_bus ();

  indexed_priority_heap_unit #(.DEPTH(DEPTH)) u_dut (
    .clk(clk), .rst_n(rst_n), .in_bus(in_bus.sink), .out_bus(out_bus.source)
  );

  req_beat_t pending_reqs[$];
  res_beat_t expected_results[$];
  int mismatch_count = 0;
  int stray_count = 0;
  bit stimulus_done = 0;
  bit calm = 0;
  int src_gap = 0;
  int sink_gap = 0;
  int idle_cycles = 0;

  int m_slot[DEPTH];
  int m_pos[DEPTH];
  int m_cnt[DEPTH];
  int m_size = 0;
  int m_cursor = 0;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  function automatic bit beats(int a, int b);
    return m_cnt[a] > m_cnt[b] || (m_cnt[a] == m_cnt[b] && a < b);
  endfunction

  function automatic void swap_slots(int i, int j);
    int t;
    if (i == j) return;
    t = m_slot[i];
    m_slot[i] = m_slot[j];
    m_slot[j] = t;
    m_pos[m_slot[i]] = i;
    m_pos[m_slot[j]] = j;
  endfunction

  function automatic void sift_up(int p);
    int up;
    while (p > 0) begin
      up = (p - 1) / 2;
      if (!beats(m_slot[p], m_slot[up])) return;
      swap_slots(p, up);
      p = up;
    end
  endfunction

  function automatic void sift_down(int p);
    int l;
    int pick;
    forever begin
      l = 2 * p + 1;
      pick = l;
      if (l >= m_size) return;
      if (l + 1 < m_size && beats(m_slot[l + 1], m_slot[l])) pick = l + 1;
      if (!beats(m_slot[pick], m_slot[p])) return;
      swap_slots(p, pick);
      p = pick;
    end
  endfunction

  function automatic bit is_queued(int e);
    return m_pos[e] < m_size && m_slot[m_pos[e]] == e;
  endfunction

  function automatic res_beat_t heap_result(req_beat_t r);
    res_beat_t res;
    int e;
    int p;
    res = '0;
    e = r.entry;
    if (r.req_type == REQ_LOAD) begin
      if (m_cursor == 0) m_size = 0;
      if (m_cursor < DEPTH) begin
        m_cnt[m_cursor] = r.count_value;
        m_slot[m_cursor] = m_cursor;
        m_pos[m_cursor] = m_cursor;
        m_cursor++;
      end else begin
        res.status = STAT_RANGE;
      end
      if (r.load_last) begin
        m_size = m_cursor;
        for (int i = m_size / 2; i > 0; i--) sift_down(i - 1);
        m_cursor = 0;
      end
    end else if (r.req_type == REQ_REMOVE || r.req_type == REQ_DEC) begin
      if (e >= DEPTH) begin
        res.status = STAT_RANGE;
      end else if (!is_queued(e)) begin
        res.status = STAT_ABSENT;
      end else if (r.req_type == REQ_REMOVE) begin
        p = m_pos[e];
        swap_slots(p, m_size - 1);
        m_size--;
        m_pos[e] = m_size;
        if (p != m_size) begin
          if (p > 0 && beats(m_slot[p], m_slot[(p - 1) / 2])) sift_up(p);
          else sift_down(p);
        end
      end else if (m_cnt[e] != 0) begin
        m_cnt[e]--;
        sift_down(m_pos[e]);
      end
      res.entry_present = (e < DEPTH) && is_queued(e);
    end
    if (m_size > 0) begin
      res.top_entry = m_slot[0];
      res.top_count = m_cnt[m_slot[0]];
    end
    res.heap_size = m_size;
    res.is_empty = (m_size == 0);
    return res;
  endfunction

  function automatic req_beat_t make_req(int kind, int e, int c, int last);
    req_beat_t r;
    r.req_type = kind;
    r.entry = e;
    r.count_value = c;
    r.load_last = last;
    return r;
  endfunction

  // A batch mostly of small sizes; loaded entries are the numbers 0..n-1.
  task automatic add_batch(int n);
    for (int i = 0; i < n; i++)
      pending_reqs.push_back(make_req(REQ_LOAD, $urandom, $urandom_range(0, 2047),
                                      i == n - 1));
  endtask

  task automatic add_random_op(int n);
    int e;
    int k;
    k = $urandom_range(0, 99);
    e = (k < 80) ? $urandom_range(0, n + 1) : $urandom_range(0, 1023);
    if (k < 45) pending_reqs.push_back(make_req(REQ_DEC, e, $urandom, $urandom));
    else if (k < 92) pending_reqs.push_back(make_req(REQ_REMOVE, e, $urandom, $urandom));
    else if (k < 97) pending_reqs.push_back(make_req(3, e, $urandom, $urandom));
    else pending_reqs.push_back(make_req(REQ_LOAD, e, $urandom, 0));
  endtask

  initial begin
    int n;
    pending_reqs.push_back(make_req(REQ_REMOVE, 0, 0, 0));
    pending_reqs.push_back(make_req(REQ_DEC, 1023, 2047, 1));
    pending_reqs.push_back(make_req(3, 5, 0, 0));
    pending_reqs.push_back(make_req(REQ_LOAD, 1023, 2047, 0));
    pending_reqs.push_back(make_req(REQ_LOAD, 0, 0, 0));
    pending_reqs.push_back(make_req(REQ_LOAD, 0, 2047, 0));
    pending_reqs.push_back(make_req(REQ_LOAD, 0, 1, 1));
    pending_reqs.push_back(make_req(REQ_DEC, 1, 0, 0));
    pending_reqs.push_back(make_req(REQ_DEC, 3, 0, 0));
    pending_reqs.push_back(make_req(REQ_DEC, 0, 0, 0));
    pending_reqs.push_back(make_req(REQ_REMOVE, 2, 0, 0));
    pending_reqs.push_back(make_req(REQ_REMOVE, 2, 0, 0));
    pending_reqs.push_back(make_req(REQ_REMOVE, 1023, 0, 0));
    pending_reqs.push_back(make_req(REQ_REMOVE, 0, 0, 0));
    pending_reqs.push_back(make_req(REQ_REMOVE, 3, 0, 0));
    pending_reqs.push_back(make_req(REQ_REMOVE, 1, 0, 0));
    pending_reqs.push_back(make_req(REQ_DEC, 1, 0, 0));
    pending_reqs.push_back(make_req(REQ_LOAD, 0, 7, 0));
    pending_reqs.push_back(make_req(REQ_LOAD, 0, 7, 1));
    pending_reqs.push_back(make_req(REQ_DEC, 0, 0, 0));
    while (pending_reqs.size() < 440) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 12);
      add_batch(n);
      repeat ($urandom_range(4, 20)) add_random_op(n);
    end
    // Full batch so the load beyond depth is reached, then a few operations.
    for (int i = 0; i <= DEPTH; i++)
      pending_reqs.push_back(make_req(REQ_LOAD, 0, $urandom_range(0, 2047), i == DEPTH));
    pending_reqs.push_back(make_req(REQ_REMOVE, 1023, 0, 0));
    pending_reqs.push_back(make_req(REQ_DEC, 512, 0, 0));
    repeat (40) add_random_op(1023);
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      in_bus.req_type <= '0;
      in_bus.entry <= '0;
      in_bus.count_value <= '0;
      in_bus.load_last <= 1'b0;
      src_gap <= 0;
    end else if (!in_bus.valid || in_bus.ready) begin
      if (in_bus.valid) expected_results.push_back(heap_result(req_beat_t'(
          {in_bus.req_type, in_bus.entry, in_bus.count_value, in_bus.load_last})));
      if (src_gap > 0) begin
        src_gap <= src_gap - 1;
        in_bus.valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        src_gap <= $urandom_range(0, 8);
        in_bus.valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        req_beat_t r;
        r = pending_reqs.pop_front();
        in_bus.valid <= 1'b1;
        {in_bus.req_type, in_bus.entry, in_bus.count_value, in_bus.load_last} <= r;
      end else begin
        in_bus.valid <= 1'b0;
        stimulus_done <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      sink_gap <= 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        res_beat_t got;
        res_beat_t want;
        got = {out_bus.top_entry, out_bus.top_count, out_bus.heap_size,
               out_bus.is_empty, out_bus.entry_present, out_bus.status};
        if (expected_results.size() == 0) begin
          stray_count++;
          mismatch_count++;
          if (mismatch_count <= 10) $display("Unexpected result beat %h", got);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("Mismatch: top %0d/%0d cnt %0d/%0d size %0d/%0d empty %0b/%0b pres %0b/%0b st %0d/%0d",
                       want.top_entry, got.top_entry, want.top_count, got.top_count,
                       want.heap_size, got.heap_size, want.is_empty, got.is_empty,
                       want.entry_present, got.entry_present, want.status, got.status);
          end
        end
      end
      if (sink_gap > 0) begin
        sink_gap <= sink_gap - 1;
        out_bus.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        sink_gap <= $urandom_range(0, 8);
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    calm <= pending_reqs.size() < 60;
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    rst_n = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    fork
      begin
        wait (stimulus_done && expected_results.size() == 0);
        repeat (200) @(posedge clk);
      end
      begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        mismatch_count++;
      end
    join_any
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("PASS indexed_priority_heap_unit");
    end else begin
      $display("FAIL indexed_priority_heap_unit");
    end
    $finish;
  end
endmodule
`default_nettype wire
